[hw/rtl/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and round functions of the sha-256 compression core
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int NUM_ROUNDS  = 64;
   localparam int MSG_WORDS   = 16;
   localparam int CHAIN_WORDS = 8;

   localparam logic [6:0] LAST_ROUND = 7'(NUM_ROUNDS - 1);
   localparam logic [3:0] LAST_MSG   = 4'(MSG_WORDS - 1);
   localparam logic [2:0] LAST_CHAIN = 3'(CHAIN_WORDS - 1);

   // request mode field codes
   localparam logic MODE_CHAIN = 1'b0;
   localparam logic MODE_MSG   = 1'b1;

   // classified command that travels through the queue
   typedef enum logic [1:0] {
      OP_CHAIN,
      OP_MSG,
      OP_START
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  idx;
      logic [31:0] data;
   } cmd_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   // round constant table
   function automatic logic [31:0] round_const(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      round_const = k;
   endfunction

endpackage

[hw/rtl/sha_if.sv]
// ----------------------------------------------------------------------------
// sha request and response channels
// valid/ready stream interfaces carrying the core's request and response
// ----------------------------------------------------------------------------
interface sha_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [3:0]  word_index;
   logic [31:0] data_word;

   modport source (output valid, output mode, output word_index, output data_word,
                   input ready);
   modport sink   (input valid, input mode, input word_index, input data_word,
                   output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  digest_index;
   logic        last_word;

   modport source (output valid, output digest_word, output digest_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input digest_index,
                   input last_word, output ready);
endinterface

[hw/rtl/sha_front.sv]
// ----------------------------------------------------------------------------
// sha_front
// accepts requests, classifies them and drops chaining words out of range
// ----------------------------------------------------------------------------
module sha_front (
   input  logic              clock,
   input  logic              reset,
   sha_req_if.sink           req,
   output logic              push_valid,
   input  logic              push_ready,
   output sha_pkg::cmd_type  push_cmd
);
   import sha_pkg::*;

   logic    held_ff, held_in;
   cmd_type cmd_ff, cmd_in;
   cmd_type cls;
   logic    drop;
   logic    accept;

   // classification
   always_comb begin
      cls.idx  = req.word_index;
      cls.data = req.data_word;
      if (req.mode == MODE_MSG) begin
         cls.op = (req.word_index == LAST_MSG) ? OP_START : OP_MSG;
      end else begin
         cls.op = OP_CHAIN;
      end
   end

   assign drop      = (req.mode == MODE_CHAIN) && (req.word_index >= 4'(CHAIN_WORDS));
   assign req.ready = !held_ff || push_ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      held_in = (held_ff && !push_ready) || (accept && !drop);
      cmd_in  = accept ? cls : cmd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
      end
      cmd_ff <= cmd_in;
   end

   assign push_valid = held_ff;
   assign push_cmd   = cmd_ff;
endmodule

[hw/rtl/sha_cmd_queue.sv]
// ----------------------------------------------------------------------------
// sha_cmd_queue
// small command fifo between the front and the compression engine
// ----------------------------------------------------------------------------
module sha_cmd_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  sha_pkg::cmd_type  push_cmd,
   output logic              head_valid,
   input  logic              pop,
   output sha_pkg::cmd_type  head_cmd
);
   import sha_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule

[hw/rtl/sha_engine.sv]
// ----------------------------------------------------------------------------
// sha_engine
// word stores, 64-round compression loop and digest output register
// ----------------------------------------------------------------------------
module sha_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  sha_pkg::cmd_type  head_cmd,
   output logic              pop,
   sha_rsp_if.source         rsp
);
   import sha_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic [2:0]  out_cnt_ff, out_cnt_in;
   logic [31:0] chain_ff [CHAIN_WORDS];
   logic [31:0] chain_in [CHAIN_WORDS];
   logic [31:0] msg_ff   [MSG_WORDS];
   logic [31:0] msg_in   [MSG_WORDS];
   logic [31:0] work_ff  [CHAIN_WORDS];
   logic [31:0] work_in  [CHAIN_WORDS];
   logic [31:0] win_ff   [MSG_WORDS];
   logic [31:0] win_in   [MSG_WORDS];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic [2:0]  rsp_idx_ff, rsp_idx_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [31:0] wt, t1, t2, ch, maj;

   assign pop = (state_ff == ST_IDLE) && head_valid;

   // one round of the compression
   always_comb begin
      if (rnd_ff < 7'(MSG_WORDS)) begin
         wt = win_ff[0];
      end else begin
         wt = win_ff[0] + small_sig0(win_ff[1]) + win_ff[9] + small_sig1(win_ff[14]);
      end
      ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
          ^ (work_ff[1] & work_ff[2]);
      t1  = work_ff[7] + big_sig1(work_ff[4]) + ch + round_const(rnd_ff[5:0]) + wt;
      t2  = big_sig0(work_ff[0]) + maj;
   end

   always_comb begin
      state_in     = state_ff;
      rnd_in       = rnd_ff;
      out_cnt_in   = out_cnt_ff;
      chain_in     = chain_ff;
      msg_in       = msg_ff;
      work_in      = work_ff;
      win_in       = win_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_word_in  = rsp_word_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               case (head_cmd.op)
                  OP_CHAIN: begin
                     chain_in[head_cmd.idx[2:0]] = head_cmd.data;
                  end
                  OP_MSG: begin
                     msg_in[head_cmd.idx] = head_cmd.data;
                  end
                  OP_START: begin
                     msg_in[head_cmd.idx] = head_cmd.data;
                     work_in              = chain_ff;
                     win_in               = msg_ff;
                     win_in[LAST_MSG]     = head_cmd.data;
                     rnd_in               = '0;
                     state_in             = ST_ROUND;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ROUND: begin
            work_in[7] = work_ff[6];
            work_in[6] = work_ff[5];
            work_in[5] = work_ff[4];
            work_in[4] = work_ff[3] + t1;
            work_in[3] = work_ff[2];
            work_in[2] = work_ff[1];
            work_in[1] = work_ff[0];
            work_in[0] = t1 + t2;
            for (int j = 0; j < MSG_WORDS - 1; j++) begin
               win_in[j] = win_ff[j + 1];
            end
            win_in[MSG_WORDS - 1] = wt;
            rnd_in = rnd_ff + 1'b1;
            if (rnd_ff == LAST_ROUND) begin
               out_cnt_in = '0;
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = chain_ff[out_cnt_ff] + work_ff[0];
               rsp_idx_in   = out_cnt_ff;
               rsp_last_in  = (out_cnt_ff == LAST_CHAIN);
               // rotate so the next word is always at the head
               for (int j = 0; j < CHAIN_WORDS - 1; j++) begin
                  work_in[j] = work_ff[j + 1];
               end
               work_in[CHAIN_WORDS - 1] = work_ff[0];
               out_cnt_in = out_cnt_ff + 1'b1;
               if (out_cnt_ff == LAST_CHAIN) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rnd_ff       <= '0;
         out_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < CHAIN_WORDS; j++) begin
            chain_ff[j] <= '0;
            work_ff[j]  <= '0;
         end
         for (int j = 0; j < MSG_WORDS; j++) begin
            msg_ff[j] <= '0;
            win_ff[j] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         out_cnt_ff   <= out_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
         msg_ff       <= msg_in;
         work_ff      <= work_in;
         win_ff       <= win_in;
      end
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.digest_word  = rsp_word_ff;
   assign rsp.digest_index = rsp_idx_ff;
   assign rsp.last_word    = rsp_last_ff;
endmodule

[hw/rtl/sha256_block_compression_core.sv]
// ----------------------------------------------------------------------------
// sha256_block_compression_core
// sha-256 compression of one 512-bit block, loaded one word per request
// ----------------------------------------------------------------------------
//
//  channel    dir   handshake      contents
//  ---------  ----  -------------  ---------------------------------------
//  req_chan   in    valid / ready  mode, word_index, data_word
//  rsp_chan   out   valid / ready  digest_word, digest_index, last_word
//
//  a load request is registered in the front, passes through the queue, and is
//  written into the engine stores from the queue head while the engine is idle;
//  loads go in at one per cycle while the engine is idle
//  message word 15 starts a compression: 64 rounds in the engine (one round per
//  cycle), then eight digest words, one per cycle when rsp is ready
//  reset is synchronous and clears the chaining and message stores to zero
//  while the engine is busy, requests fill the front register and queue, and
//  req_chan.ready drops once both are full; rsp stalls hold the engine
//
module sha256_block_compression_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   sha_req_if.sink   req_chan,
   sha_rsp_if.source rsp_chan
);
   import sha_pkg::*;

   // front to queue
   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;

   // queue to engine
   logic    head_valid;
   logic    head_pop;
   cmd_type head_cmd;

   // classify requests, drop chaining words out of range
   sha_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // decouples the front from the engine while a block is compressed
   sha_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .head_valid (head_valid),
      .pop        (head_pop),
      .head_cmd   (head_cmd)
   );

   // stores, round loop and digest output
   sha_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (head_pop),
      .rsp        (rsp_chan)
   );

   // engine never takes a command from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("engine popped an empty queue");

   // a command the queue refused stays offered by the front
   a_push_holds: assert property (@(posedge clock) disable iff (reset)
      push_valid && !push_ready |=> push_valid && $stable(push_cmd))
      else $error("front dropped a refused command");

   // the flagged word is always digest word h
   a_last_is_h: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.last_word |-> rsp_chan.digest_index == LAST_CHAIN)
      else $error("last flag on a word other than h");

endmodule
